// ----- rtl/vtr_pkg.sv -----
// ----------------------------------------------------------------------------
// vtr_pkg
// Shared types and codes for the versioned table reconciler.
// ----------------------------------------------------------------------------
package vtr_pkg;

    localparam int HELD_DEPTH_DEF    = 16;
    localparam int CATALOG_DEPTH_DEF = 16;

    // input modes
    localparam logic [2:0] MODE_MARK   = 3'd0;
    localparam logic [2:0] MODE_DROP   = 3'd1;
    localparam logic [2:0] MODE_QUERY  = 3'd2;
    localparam logic [2:0] MODE_START  = 3'd3;
    localparam logic [2:0] MODE_ENTRY  = 3'd4;
    localparam logic [2:0] MODE_FINISH = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_PRUNE   = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic hscan;
        logic cscan;
        logic cupd;
        logic hupd;
        logic req;
        logic prune;
        logic fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic h_scan_done;
        logic c_scan_done;
        logic req_end;
        logic prune_end;
        logic slot_free;
    } t_stat;

endpackage

// ----- rtl/vtr_ctrl.sv -----
// ----------------------------------------------------------------------------
// vtr_ctrl
// Sequencer: steps each item through lookup, update and report phases.
// ----------------------------------------------------------------------------
module vtr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [2:0]    i_mode,
    output logic          o_ready,
    output vtr_pkg::t_cmd o_cmd,
    input  vtr_pkg::t_stat i_stat
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_HSCAN = 8'b0000_0010,
        S_CSCAN = 8'b0000_0100,
        S_CUPD  = 8'b0000_1000,
        S_HUPD  = 8'b0001_0000,
        S_REQ   = 8'b0010_0000,
        S_PRUNE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = (r_state == S_IDLE) && i_valid;
        o_cmd.hscan  = (r_state == S_HSCAN);
        o_cmd.cscan  = (r_state == S_CSCAN);
        o_cmd.cupd   = (r_state == S_CUPD);
        o_cmd.hupd   = (r_state == S_HUPD);
        o_cmd.req    = (r_state == S_REQ);
        o_cmd.prune  = (r_state == S_PRUNE);
        o_cmd.fin    = (r_state == S_DONE);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    priority if (i_mode == vtr_pkg::MODE_ENTRY)       n_state = S_CSCAN;
                    else if (i_mode == vtr_pkg::MODE_FINISH)          n_state = S_REQ;
                    else if (i_mode == vtr_pkg::MODE_MARK || i_mode == vtr_pkg::MODE_DROP ||
                             i_mode == vtr_pkg::MODE_QUERY || i_mode == vtr_pkg::MODE_START)
                        n_state = S_HSCAN;
                    else                                              n_state = S_IDLE;
                end
            end
            S_CSCAN: if (i_stat.c_scan_done) n_state = S_CUPD;
            S_CUPD:  n_state = S_HSCAN;
            S_HSCAN: if (i_stat.h_scan_done) n_state = S_HUPD;
            S_HUPD:  if (i_stat.slot_free) n_state = S_IDLE;
            S_REQ:   if (i_stat.req_end) n_state = S_PRUNE;
            S_PRUNE: if (i_stat.prune_end) n_state = S_DONE;
            S_DONE:  if (i_stat.slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    a_onehot_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.hscan, o_cmd.cscan, o_cmd.cupd, o_cmd.hupd,
                  o_cmd.req, o_cmd.prune, o_cmd.fin}))
        else $error("more than one phase command");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> o_ready)
        else $error("accept outside idle");
    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.fin && i_stat.slot_free) |=> o_ready)
        else $error("done report did not return to idle");

endmodule

// ----- rtl/vtr_dp.sv -----
// ----------------------------------------------------------------------------
// vtr_dp
// Datapath: held and catalog tables, scan pointers and the result register.
// ----------------------------------------------------------------------------
module vtr_dp #(
    parameter int HELD_DEPTH    = vtr_pkg::HELD_DEPTH_DEF,
    parameter int CATALOG_DEPTH = vtr_pkg::CATALOG_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vtr_pkg::t_cmd  i_cmd,
    output vtr_pkg::t_stat o_stat,
    input  logic [2:0]     i_mode,
    input  logic [31:0]    i_key,
    input  logic [31:0]    i_ver,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [1:0]     o_kind,
    output logic [31:0]    o_key,
    output logic [31:0]    o_hv,
    output logic           o_present,
    output logic           o_overflow,
    output logic           o_last
);

    localparam int HIW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
    localparam int CIW = (CATALOG_DEPTH > 1) ? $clog2(CATALOG_DEPTH) : 1;
    localparam int HPW = $clog2(HELD_DEPTH + 1);
    localparam int CPW = $clog2(CATALOG_DEPTH + 1);

    logic [31:0]    r_hkey [HELD_DEPTH];
    logic [31:0]    r_hver [HELD_DEPTH];
    logic [31:0]    r_ckey [CATALOG_DEPTH];
    logic [31:0]    r_cver [CATALOG_DEPTH];
    logic [HPW-1:0] r_hcnt, r_ha;
    logic [CPW-1:0] r_ccnt, r_ca;
    logic [31:0]    r_stamp;
    logic           r_covf, r_entry_ovf;
    logic [2:0]     r_mode;
    logic [31:0]    r_key, r_ver;

    logic           r_out_valid, r_out_pres, r_out_ovf, r_out_last;
    logic [1:0]     r_out_kind;
    logic [31:0]    r_out_key, r_out_hv;

    logic [31:0]    w_hk, w_hv, w_ck, w_cv;
    logic           w_h_ok, w_c_ok, w_slot, w_hfound, w_cfound;
    logic           w_load, w_lpres, w_lovf, w_llast, w_hstep, w_cstep;
    logic [1:0]     w_lkind;
    logic [31:0]    w_lkey, w_lhv;

    assign w_hk   = r_hkey[r_ha[HIW-1:0]];
    assign w_hv   = r_hver[r_ha[HIW-1:0]];
    assign w_ck   = r_ckey[r_ca[CIW-1:0]];
    assign w_cv   = r_cver[r_ca[CIW-1:0]];
    assign w_h_ok = (r_ha < r_hcnt);
    assign w_c_ok = (r_ca < r_ccnt);
    assign w_slot = !r_out_valid || i_out_ready;
    assign w_hfound = w_h_ok && (w_hk == r_key);
    assign w_cfound = w_c_ok && (w_ck == r_key);

    assign o_stat.h_scan_done = !(w_h_ok && (w_hk < r_key));
    assign o_stat.c_scan_done = !(w_c_ok && (w_ck < r_key));
    assign o_stat.req_end     = !w_c_ok;
    assign o_stat.prune_end   = !w_h_ok;
    assign o_stat.slot_free   = w_slot;

    // result selection and merge-walk stepping
    always_comb begin
        w_load  = 1'b0;
        w_lkind = vtr_pkg::KIND_STATUS;
        w_lkey  = r_key;
        w_lhv   = '0;
        w_lpres = 1'b0;
        w_lovf  = 1'b0;
        w_llast = 1'b0;
        w_hstep = 1'b0;
        w_cstep = 1'b0;
        priority if (i_cmd.hupd) begin
            w_load  = w_slot;
            w_llast = 1'b1;
            priority if (r_mode == vtr_pkg::MODE_MARK) begin
                priority if (w_hfound) begin
                    w_lpres = 1'b1;
                    w_lhv   = (r_ver > w_hv) ? r_ver : w_hv;
                end else if (r_hcnt >= HPW'(HELD_DEPTH)) begin
                    w_lovf = 1'b1;
                end else begin
                    w_lpres = 1'b1;
                    w_lhv   = r_ver;
                end
            end else if (r_mode == vtr_pkg::MODE_DROP) begin
                w_lpres = 1'b0;
            end else begin
                w_lpres = w_hfound;
                w_lhv   = w_hfound ? w_hv : '0;
                w_lovf  = (r_mode == vtr_pkg::MODE_ENTRY) && r_entry_ovf;
            end
        end else if (i_cmd.req) begin
            if (w_c_ok) begin
                priority if (w_h_ok && (w_hk < w_ck)) begin
                    w_hstep = 1'b1;
                end else if (!(w_h_ok && (w_hk == w_ck))) begin
                    w_load  = w_slot;
                    w_cstep = w_slot;
                end else if (w_hv < w_cv) begin
                    w_load  = w_slot;
                    w_cstep = w_slot;
                    w_lpres = 1'b1;
                    w_lhv   = w_hv;
                end else begin
                    w_cstep = 1'b1;
                end
            end
            w_lkind = vtr_pkg::KIND_REQUEST;
            w_lkey  = w_ck;
        end else if (i_cmd.prune) begin
            if (w_h_ok) begin
                priority if (w_c_ok && (w_ck < w_hk)) begin
                    w_cstep = 1'b1;
                end else if (!(w_c_ok && (w_ck == w_hk)) && (w_hv < r_stamp)) begin
                    w_load  = w_slot;
                    w_hstep = w_slot;
                end else begin
                    w_hstep = 1'b1;
                end
            end
            w_lkind = vtr_pkg::KIND_PRUNE;
            w_lkey  = w_hk;
            w_lhv   = w_hv;
            w_lpres = 1'b1;
        end else if (i_cmd.fin) begin
            w_load  = w_slot;
            w_lkind = vtr_pkg::KIND_DONE;
            w_lkey  = '0;
            w_lovf  = r_covf;
            w_llast = 1'b1;
        end else begin
            w_load = 1'b0;
        end
        if (i_cmd.hscan) w_hstep = !o_stat.h_scan_done;
        if (i_cmd.cscan) w_cstep = !o_stat.c_scan_done;
    end

    // table storage; shifts move every entry from a fixed neighbor
    always_ff @(posedge i_clk) begin
        if (i_cmd.cupd && !w_cfound && (r_ccnt < CPW'(CATALOG_DEPTH))) begin
            for (int j = 1; j < CATALOG_DEPTH; j++) begin
                if (CPW'(j) > r_ca) begin
                    r_ckey[j] <= r_ckey[j-1];
                    r_cver[j] <= r_cver[j-1];
                end
            end
            r_ckey[r_ca[CIW-1:0]] <= r_key;
            r_cver[r_ca[CIW-1:0]] <= r_ver;
        end else if (i_cmd.cupd && w_cfound && (r_ver > w_cv)) begin
            r_cver[r_ca[CIW-1:0]] <= r_ver;
        end
        if (i_cmd.hupd && w_slot && r_mode == vtr_pkg::MODE_MARK) begin
            if (w_hfound) begin
                if (r_ver > w_hv) r_hver[r_ha[HIW-1:0]] <= r_ver;
            end else if (r_hcnt < HPW'(HELD_DEPTH)) begin
                for (int j = 1; j < HELD_DEPTH; j++) begin
                    if (HPW'(j) > r_ha) begin
                        r_hkey[j] <= r_hkey[j-1];
                        r_hver[j] <= r_hver[j-1];
                    end
                end
                r_hkey[r_ha[HIW-1:0]] <= r_key;
                r_hver[r_ha[HIW-1:0]] <= r_ver;
            end
        end else if (i_cmd.hupd && w_slot && r_mode == vtr_pkg::MODE_DROP && w_hfound) begin
            for (int j = 0; j < HELD_DEPTH - 1; j++) begin
                if (HPW'(j) >= r_ha) begin
                    r_hkey[j] <= r_hkey[j+1];
                    r_hver[j] <= r_hver[j+1];
                end
            end
        end
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_key  <= i_key;
            r_ver  <= i_ver;
        end
        if (w_load) begin
            r_out_kind <= w_lkind;
            r_out_key  <= w_lkey;
            r_out_hv   <= w_lhv;
            r_out_pres <= w_lpres;
            r_out_ovf  <= w_lovf;
            r_out_last <= w_llast;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt      <= '0;
            r_ccnt      <= '0;
            r_ha        <= '0;
            r_ca        <= '0;
            r_stamp     <= '0;
            r_covf      <= 1'b0;
            r_entry_ovf <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load)           r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            if (w_hstep) r_ha <= r_ha + HPW'(1);
            if (w_cstep) r_ca <= r_ca + CPW'(1);
            if (i_cmd.accept) begin
                r_ha        <= '0;
                r_ca        <= '0;
                r_entry_ovf <= 1'b0;
                if (i_mode == vtr_pkg::MODE_START) begin
                    r_ccnt  <= '0;
                    r_stamp <= i_ver;
                    r_covf  <= 1'b0;
                end
            end
            if (i_cmd.cupd && !w_cfound) begin
                if (r_ccnt < CPW'(CATALOG_DEPTH)) begin
                    r_ccnt <= r_ccnt + CPW'(1);
                end else begin
                    r_covf      <= 1'b1;
                    r_entry_ovf <= 1'b1;
                end
            end
            if (i_cmd.hupd && w_slot && r_mode == vtr_pkg::MODE_MARK && !w_hfound &&
                r_hcnt < HPW'(HELD_DEPTH))
                r_hcnt <= r_hcnt + HPW'(1);
            if (i_cmd.hupd && w_slot && r_mode == vtr_pkg::MODE_DROP && w_hfound)
                r_hcnt <= r_hcnt - HPW'(1);
            // rewind both walks between the request and prune passes
            if (i_cmd.req && !w_c_ok) begin
                r_ha <= '0;
                r_ca <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_key       = r_out_key;
    assign o_hv        = r_out_hv;
    assign o_present   = r_out_pres;
    assign o_overflow  = r_out_ovf;
    assign o_last      = r_out_last;

    a_hcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= HPW'(HELD_DEPTH))
        else $error("held count beyond depth");
    a_ccnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ccnt <= CPW'(CATALOG_DEPTH))
        else $error("catalog count beyond depth");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_slot)
        else $error("result overwritten while stalled");

endmodule

// ----- rtl/versioned_table_reconciler.sv -----
// ----------------------------------------------------------------------------
// versioned_table_reconciler
// Sorted tile table with versions, reconciled against a streamed catalog.
// ----------------------------------------------------------------------------
// Input stream (s side): tuser carries the mode, tdata the key and version.
// Output stream (m side): tuser carries the result kind, tlast marks the
// final result of an input item.
// One item is worked at a time; s_tready is high only while idle.
// Single ops walk the held table one entry per cycle; a catalog entry
// also walks the catalog first.
// A finish runs two merge walks over both tables, one step per cycle
// while the receiver takes results, then reports done.
// The result register lets the next item be taken while a result waits.
// A stalled receiver holds the walk at the next result to send.
// Reset empties both tables, clears the generation time and the
// overflow flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module versioned_table_reconciler #(
    parameter int HELD_DEPTH    = vtr_pkg::HELD_DEPTH_DEF,
    parameter int CATALOG_DEPTH = vtr_pkg::CATALOG_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // tile_key[31:0], version[63:32]
    input  logic [2:0]  i_s_tuser,  // mode[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,  // out_key[31:0], held_version[63:32],
                                    // present[64], overflow[65], zero[71:66]
    output logic [1:0]  o_m_tuser,  // kind[1:0]
    output logic        o_m_tlast
);

    vtr_pkg::t_cmd  w_cmd;
    vtr_pkg::t_stat w_stat;
    logic [31:0]    w_key, w_hv;
    logic           w_pres, w_ovf;

    vtr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_mode  (i_s_tuser),
        .o_ready (o_s_tready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    vtr_dp #(
        .HELD_DEPTH    (HELD_DEPTH),
        .CATALOG_DEPTH (CATALOG_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_mode      (i_s_tuser),
        .i_key       (i_s_tdata[31:0]),
        .i_ver       (i_s_tdata[63:32]),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_kind      (o_m_tuser),
        .o_key       (w_key),
        .o_hv        (w_hv),
        .o_present   (w_pres),
        .o_overflow  (w_ovf),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {6'd0, w_ovf, w_pres, w_hv, w_key};

endmodule

// ----- bench/versioned_table_reconciler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// versioned_table_reconciler_tb
// Self-checking bench for the versioned tile table and catalog reconciler.
// Items go in over the slave stream; a behavioral copy of the held table and
// the catalog predicts every status, request, prune and done transfer, and a
// checker compares each output transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module versioned_table_reconciler_tb;

    localparam int HDEPTH = vtr_pkg::HELD_DEPTH_DEF;
    localparam int CDEPTH = vtr_pkg::CATALOG_DEPTH_DEF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [31:0] ver;
        logic        present;
        logic        overflow;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;   // tile_key[31:0], version[63:32]
    logic [2:0]  i_s_tuser = '0;   // mode[2:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;        // out_key, held_version, present, overflow
    logic [1:0]  o_m_tuser;        // kind[1:0]
    logic        o_m_tlast;

    versioned_table_reconciler dut (.*);

    initial forever #1 i_clk = ~i_clk;

    // predicted table contents
    logic [31:0] held_k [HDEPTH];
    logic [31:0] held_v [HDEPTH];
    int          held_n = 0;
    logic [31:0] cat_k [CDEPTH];
    logic [31:0] cat_v [CDEPTH];
    int          cat_n = 0;
    logic [31:0] gen_time = '0;
    logic        cat_ovf = 1'b0;

    t_result pending_results[$];
    int      errors = 0;
    int      items_sent = 0;
    int      results_seen = 0;
    int      hold_off = 0;     // receiver stall cycles forced by a test
    int      n_req = 0, n_prune = 0, n_ovf = 0;

    function automatic void queue_result(t_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic t_result held_status(logic [31:0] k, logic ovf);
        t_result r;
        int p;
        p = 0;
        while (p < held_n && held_k[p] < k) p++;
        r = '{vtr_pkg::KIND_STATUS, k, 32'd0, 1'b0, ovf, 1'b1};
        if (p < held_n && held_k[p] == k) begin
            r.ver = held_v[p];
            r.present = 1'b1;
        end
        return r;
    endfunction

    // apply one item to the predicted tables and queue its results
    task automatic predict_item(logic [2:0] mode, logic [31:0] k, logic [31:0] v);
        int p, q, i;
        logic ovf, hit;
        ovf = 1'b0;
        case (mode)
            vtr_pkg::MODE_MARK, vtr_pkg::MODE_ENTRY: begin
                if (mode == vtr_pkg::MODE_MARK) begin
                    p = 0;
                    while (p < held_n && held_k[p] < k) p++;
                    if (p < held_n && held_k[p] == k) begin
                        if (v > held_v[p]) held_v[p] = v;
                    end else if (held_n >= HDEPTH) begin
                        ovf = 1'b1;
                    end else begin
                        for (i = held_n; i > p; i--) begin
                            held_k[i] = held_k[i-1];
                            held_v[i] = held_v[i-1];
                        end
                        held_k[p] = k; held_v[p] = v; held_n++;
                    end
                end else begin
                    p = 0;
                    while (p < cat_n && cat_k[p] < k) p++;
                    if (p < cat_n && cat_k[p] == k) begin
                        if (v > cat_v[p]) cat_v[p] = v;
                    end else if (cat_n >= CDEPTH) begin
                        ovf = 1'b1;
                        cat_ovf = 1'b1;
                    end else begin
                        for (i = cat_n; i > p; i--) begin
                            cat_k[i] = cat_k[i-1];
                            cat_v[i] = cat_v[i-1];
                        end
                        cat_k[p] = k; cat_v[p] = v; cat_n++;
                    end
                end
                if (ovf) n_ovf++;
                queue_result(held_status(k, ovf));
            end
            vtr_pkg::MODE_DROP: begin
                p = 0;
                while (p < held_n && held_k[p] < k) p++;
                if (p < held_n && held_k[p] == k) begin
                    for (i = p; i + 1 < held_n; i++) begin
                        held_k[i] = held_k[i+1];
                        held_v[i] = held_v[i+1];
                    end
                    held_n--;
                end
                queue_result(held_status(k, 1'b0));
            end
            vtr_pkg::MODE_QUERY: queue_result(held_status(k, 1'b0));
            vtr_pkg::MODE_START: begin
                cat_n = 0;
                gen_time = v;
                cat_ovf = 1'b0;
                queue_result(held_status(k, 1'b0));
            end
            vtr_pkg::MODE_FINISH: begin
                for (i = 0; i < cat_n; i++) begin
                    q = 0;
                    while (q < held_n && held_k[q] < cat_k[i]) q++;
                    hit = (q < held_n && held_k[q] == cat_k[i]);
                    if (!hit) begin
                        queue_result('{vtr_pkg::KIND_REQUEST, cat_k[i], 32'd0,
                                       1'b0, 1'b0, 1'b0});
                        n_req++;
                    end else if (held_v[q] < cat_v[i]) begin
                        queue_result('{vtr_pkg::KIND_REQUEST, cat_k[i], held_v[q],
                                       1'b1, 1'b0, 1'b0});
                        n_req++;
                    end
                end
                for (i = 0; i < held_n; i++) begin
                    q = 0;
                    while (q < cat_n && cat_k[q] < held_k[i]) q++;
                    hit = (q < cat_n && cat_k[q] == held_k[i]);
                    if (!hit && held_v[i] < gen_time) begin
                        queue_result('{vtr_pkg::KIND_PRUNE, held_k[i], held_v[i],
                                       1'b1, 1'b0, 1'b0});
                        n_prune++;
                    end
                end
                queue_result('{vtr_pkg::KIND_DONE, 32'd0, 32'd0, 1'b0, cat_ovf, 1'b1});
            end
            default: ;
        endcase
    endtask

    // random gap, mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // keep tvalid up across back-to-back items; drop it only for a gap
    task automatic send_item(logic [2:0] mode, logic [31:0] k, logic [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {v, k};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_item(mode, k, v);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls plus forced hold-off
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                i_m_tready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    // result checker
    initial begin
        t_result got, exp_r;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got = '{o_m_tuser, o_m_tdata[31:0], o_m_tdata[63:32], o_m_tdata[64],
                        o_m_tdata[65], o_m_tlast};
                results_seen++;
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transfer: kind %0d key %h", got.kind, got.key);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got !== exp_r) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: exp k%0d key %h ver %h p%b o%b l%b",
                                     exp_r.kind, exp_r.key, exp_r.ver, exp_r.present,
                                     exp_r.overflow, exp_r.last);
                            $display("          got k%0d key %h ver %h p%b o%b l%b",
                                     got.kind, got.key, got.ver, got.present,
                                     got.overflow, got.last);
                        end
                    end
                end
            end
        end
    end

    // random key from a small pool so hits, raises and prunes happen often
    function automatic logic [31:0] pool_key();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return 32'h1000 + $urandom_range(0, 23);
    endfunction

    task automatic test_directed();
        send_item(vtr_pkg::MODE_QUERY, 32'h0, 32'h0);
        send_item(vtr_pkg::MODE_FINISH, 32'h0, 32'h0);          // finish with no catalog
        send_item(vtr_pkg::MODE_ENTRY, 32'hFFFF_FFFF, 32'h5);   // entry without a start
        send_item(vtr_pkg::MODE_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(vtr_pkg::MODE_MARK, 32'h0, 32'h0);
        send_item(vtr_pkg::MODE_MARK, 32'h0, 32'h7);            // raise
        send_item(vtr_pkg::MODE_MARK, 32'h0, 32'h3);            // no lowering
        send_item(vtr_pkg::MODE_DROP, 32'h1234, 32'h0);         // drop of a key not held
        send_item(vtr_pkg::MODE_QUERY, 32'hFFFF_FFFF, 32'h0);
        send_item(3'd6, 32'hAAAA_5555, 32'h5555_AAAA);          // unused modes ignored
        send_item(3'd7, 32'h5555_AAAA, 32'hAAAA_5555);
        send_item(vtr_pkg::MODE_START, 32'h77, 32'hFFFF_FFFF);
        send_item(vtr_pkg::MODE_ENTRY, 32'h0, 32'h9);
        send_item(vtr_pkg::MODE_ENTRY, 32'h0, 32'h2);           // repeated key keeps the higher version
        send_item(vtr_pkg::MODE_ENTRY, 32'h8000_0000, 32'h1);
        send_item(vtr_pkg::MODE_FINISH, 32'h0, 32'h0);
        send_item(vtr_pkg::MODE_FINISH, 32'h0, 32'h0);          // repeat report
        send_item(vtr_pkg::MODE_DROP, 32'h0, 32'h0);
        send_item(vtr_pkg::MODE_DROP, 32'hFFFF_FFFF, 32'h0);
        wait_drained();
    endtask

    // fill both tables past capacity
    task automatic test_overflow();
        int i;
        for (i = 0; i < HDEPTH + 2; i++)
            send_item(vtr_pkg::MODE_MARK, 32'h2000 + i * 3, $urandom_range(0, 50));
        send_item(vtr_pkg::MODE_MARK, 32'h2000, 32'h100);       // raise still works when full
        send_item(vtr_pkg::MODE_START, 32'h0, 32'd30);
        for (i = 0; i < CDEPTH + 2; i++)
            send_item(vtr_pkg::MODE_ENTRY, 32'h2000 + i * 2, $urandom_range(0, 60));
        send_item(vtr_pkg::MODE_FINISH, 32'h0, 32'h0);          // worst-case report
        wait_drained();
        for (i = 0; i < HDEPTH + 2; i++)
            send_item(vtr_pkg::MODE_DROP, 32'h2000 + i * 3, 32'h0);
        wait_drained();
    endtask

    // receiver holds off while items keep coming
    task automatic test_backpressure();
        int i;
        hold_off = 200;
        for (i = 0; i < 6; i++) send_item(vtr_pkg::MODE_QUERY, pool_key(), 32'h0);
        wait_drained();
    endtask

    task automatic test_random();
        int n, i, j;
        logic [2:0] mode;
        n = 0;
        while (n < 30) begin
            if ($urandom_range(0, 3) != 0) begin
                // well-formed catalog round with random content
                send_item(vtr_pkg::MODE_START, pool_key(), $urandom_range(0, 40));
                j = $urandom_range(1, 8);
                for (i = 0; i < j; i++)
                    send_item(vtr_pkg::MODE_ENTRY, pool_key(), $urandom_range(0, 40));
                send_item(vtr_pkg::MODE_FINISH, $urandom(), $urandom());
                n += j + 2;
            end else begin
                for (i = 0; i < 4; i++) begin
                    mode = 3'($urandom_range(0, 5));
                    send_item(mode, pool_key(),
                              $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom());
                end
                n += 4;
            end
            if (held_n > 12)
                for (i = 0; i < 4; i++) send_item(vtr_pkg::MODE_DROP, pool_key(), 32'h0);
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("covered %0d items, %0d transfers: %0d requests, %0d prunes, %0d overflows",
                 items_sent, results_seen, n_req, n_prune, n_ovf);
        if (errors == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d transfers outstanding", pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
